@@ rtl/nfcrx_pkg.sv @@
// Shared types, codes and constants of the response frame receiver.
// No dependencies; every other file of the block refers to it by scoped name.
package nfcrx_pkg;

  localparam int BODY_BYTES_DEF = 64;
  localparam int MAX_PAYLOAD    = 61;

  localparam logic [7:0] RESP_TFI = 8'hD5;

  // request codes
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  // status codes
  localparam logic [3:0] STAT_OK         = 4'd0;
  localparam logic [3:0] STAT_ACK_SHORT  = 4'd1;
  localparam logic [3:0] STAT_ACK_BAD    = 4'd2;
  localparam logic [3:0] STAT_HDR_SHORT  = 4'd3;
  localparam logic [3:0] STAT_BAD_START  = 4'd4;
  localparam logic [3:0] STAT_LCS_BAD    = 4'd5;
  localparam logic [3:0] STAT_LEN_RANGE  = 4'd6;
  localparam logic [3:0] STAT_TOO_LONG   = 4'd7;
  localparam logic [3:0] STAT_BODY_SHORT = 4'd8;
  localparam logic [3:0] STAT_BAD_TFI    = 4'd9;
  localparam logic [3:0] STAT_BAD_DCS    = 4'd10;

  // ACK frame 00 00 FF 00 FF 00
  function automatic logic [7:0] ack_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd2, 3'd4: val = 8'hFF;
      default:    val = 8'h00;
    endcase
    return val;
  endfunction

  typedef struct packed {
    logic       start;
    logic       ack_byte;
    logic       hdr_byte;
    logic       hdr_take;
    logic       body_byte;
    logic       drain_init;
    logic       rd_issue;
    logic       rd_load;
    logic       err_push;
    logic       empty_push;
    logic [3:0] err_code;
  } cmd_t;

  typedef struct packed {
    logic       ack_last;
    logic       ack_bad;
    logic       hdr_last;
    logic [3:0] hdr_code;
    logic       body_last;
    logic [3:0] fin_code;
    logic       plen_zero;
    logic       drain_last;
  } stat_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [5:0] data_len;
    logic       last;
  } res_t;

endpackage

@@ rtl/nfc_response_frame_receiver_top.sv @@
// Reader response frame receiver: controller, datapath and result buffer.
// Depends on nfcrx_pkg, nfcrx_ctrl, nfcrx_dp and nfcrx_outq.
//
// A start request arms one reception and latches max_payload; a byte request
// delivers one received byte, a timeout request closes the reception with a
// short-read status. With ack_first set the six-byte ACK frame is checked
// first, then a five-byte header with start code 00 00 FF or 00 FF, LEN and
// LCS, then TFI, data, DCS and postamble are buffered in the body memory.
// Only a frame with good LCS, length, TFI 0xD5 and DCS releases its payload,
// one result per byte, in order, the last flagged by last; an empty payload
// gives one ok result with byte_valid low. Any failure gives a single status
// result with last set. The fifth header byte is followed by a stall
// while the header is evaluated, and the final body byte by one for the
// TFI and DCS check. The payload is then read out of the body memory
// (one write port, one registered read port) byte by byte: a read, a load of
// the registered read data, then a wait while the result leaves the holding
// slot, so the request side stays stalled for the whole read-out. Results
// pass through a holding slot and an output register, so one finished
// result may wait on out_stall while further requests are taken. The
// ack_first register (reset 1) is always writable and is sampled on start
// requests; cfg_ready is always high.
module nfc_response_frame_receiver_top #(
  parameter int BODY_BYTES = nfcrx_pkg::BODY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] rx_byte,
  input  logic [5:0] max_payload,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic [5:0] data_len,
  output logic       last,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  nfcrx_pkg::cmd_t  cmd;
  nfcrx_pkg::stat_t stat;
  nfcrx_pkg::res_t  push_res;
  nfcrx_pkg::res_t  out_res;
  logic             push;
  logic             res_free;

  assign cfg_ready = 1'b1;

  nfcrx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .res_free  (res_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfcrx_dp #(
    .BODY_BYTES (BODY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .max_payload (max_payload),
    .cmd         (cmd),
    .stat        (stat),
    .push        (push),
    .push_res    (push_res)
  );

  nfcrx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // hand the buffered result out on separate ports
  assign status       = out_res.status;
  assign payload_byte = out_res.payload_byte;
  assign byte_valid   = out_res.byte_valid;
  assign data_len     = out_res.data_len;
  assign last         = out_res.last;

endmodule

@@ rtl/nfcrx_ctrl.sv @@
// Reception controller: phase sequencing, request acceptance and ack_first register.
// Depends on nfcrx_pkg; drives the datapath through nfcrx_pkg::cmd_t.
module nfcrx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic                 cfg_valid,
  input  logic                 cfg_data,
  input  logic                 res_free,
  input  nfcrx_pkg::stat_t     stat,
  output nfcrx_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ACK  = 7'b0000010,
    ST_HDR  = 7'b0000100,
    ST_BODY = 7'b0001000,
    ST_EVAL = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_READ = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   ack_first;
  logic   loading;
  logic   loading_next;
  logic   accepting;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ack_first <= 1'b1;
      loading   <= 1'b0;
    end else begin
      state   <= state_next;
      loading <= loading_next;
      if (cfg_valid) begin
        ack_first <= cfg_data;
      end
    end
  end

  always_comb begin
    accepting = (state inside {ST_IDLE, ST_ACK, ST_HDR, ST_BODY});
    in_stall  = !(accepting && res_free);
    acc       = in_valid && !in_stall;
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    loading_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (acc && req_type == nfcrx_pkg::REQ_START) begin
          cmd.start  = 1'b1;
          state_next = ack_first ? ST_ACK : ST_HDR;
        end
      end
      ST_ACK, ST_HDR, ST_BODY: begin
        if (acc) begin
          if (req_type == nfcrx_pkg::REQ_START) begin
            cmd.start  = 1'b1;
            state_next = ack_first ? ST_ACK : ST_HDR;
          end else if (req_type == nfcrx_pkg::REQ_TIMEOUT) begin
            cmd.err_push = 1'b1;
            state_next   = ST_IDLE;
            if (state == ST_ACK) begin
              cmd.err_code = nfcrx_pkg::STAT_ACK_SHORT;
            end else if (state == ST_HDR) begin
              cmd.err_code = nfcrx_pkg::STAT_HDR_SHORT;
            end else begin
              cmd.err_code = nfcrx_pkg::STAT_BODY_SHORT;
            end
          end else if (req_type == nfcrx_pkg::REQ_BYTE) begin
            if (state == ST_ACK) begin
              cmd.ack_byte = 1'b1;
              if (stat.ack_last) begin
                if (stat.ack_bad) begin
                  cmd.err_push = 1'b1;
                  cmd.err_code = nfcrx_pkg::STAT_ACK_BAD;
                  state_next   = ST_IDLE;
                end else begin
                  state_next = ST_HDR;
                end
              end
            end else if (state == ST_HDR) begin
              cmd.hdr_byte = 1'b1;
              if (stat.hdr_last) begin
                state_next = ST_EVAL;
              end
            end else begin
              cmd.body_byte = 1'b1;
              if (stat.body_last) begin
                state_next = ST_FIN;
              end
            end
          end
        end
      end
      ST_EVAL: begin
        if (res_free) begin
          if (stat.hdr_code == nfcrx_pkg::STAT_OK) begin
            cmd.hdr_take = 1'b1;
            state_next   = ST_BODY;
          end else begin
            cmd.err_push = 1'b1;
            cmd.err_code = stat.hdr_code;
            state_next   = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (res_free) begin
          if (stat.fin_code != nfcrx_pkg::STAT_OK) begin
            cmd.err_push = 1'b1;
            cmd.err_code = stat.fin_code;
            state_next   = ST_IDLE;
          end else if (stat.plen_zero) begin
            cmd.empty_push = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            cmd.drain_init = 1'b1;
            state_next     = ST_READ;
          end
        end
      end
      ST_READ: begin
        // loading: read data for the previous issue is on the memory output
        if (loading) begin
          cmd.rd_load = 1'b1;
          if (stat.drain_last) begin
            state_next = ST_IDLE;
          end
        end else if (res_free) begin
          cmd.rd_issue = 1'b1;
          loading_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.err_push || cmd.empty_push || cmd.rd_load) |-> res_free)
    else $error("result pushed while result slot occupied");

  a_timeout_ends: assert property (@(posedge clk) disable iff (rst)
    (acc && req_type == nfcrx_pkg::REQ_TIMEOUT && state != ST_IDLE) |=> (state == ST_IDLE))
    else $error("timeout did not end the reception");

  a_load_after_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_load |-> $past(cmd.rd_issue))
    else $error("payload load without a preceding read");

endmodule

@@ rtl/nfcrx_dp.sv @@
// Reception datapath: counters, checksums, header bytes, body memory and result forming.
// Depends on nfcrx_pkg; obeys nfcrx_pkg::cmd_t and reports nfcrx_pkg::stat_t.
module nfcrx_dp #(
  parameter int BODY_BYTES = nfcrx_pkg::BODY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  logic [5:0]        max_payload,
  input  nfcrx_pkg::cmd_t   cmd,
  output nfcrx_pkg::stat_t  stat,
  output logic              push,
  output nfcrx_pkg::res_t   push_res
);

  localparam int AW = $clog2(BODY_BYTES);

  logic [5:0]    byte_index;
  logic [7:0]    frame_len;
  logic [7:0]    running_sum;
  logic [5:0]    limit_latched;
  logic [7:0]    tfi;
  logic [5:0]    drain_cnt;
  logic [7:0]    hdr [5];
  logic [7:0]    body_mem [BODY_BYTES];
  logic [7:0]    rdata;

  logic          long_form;
  logic          short_form;
  logic [7:0]    len;
  logic [7:0]    lcs;
  logic [7:0]    lcs_sum;
  logic [5:0]    plen;
  logic [8:0]    len_limit;
  logic [9:0]    len_room;

  always_comb begin
    long_form  = hdr[0] == 8'h00 && hdr[1] == 8'h00 && hdr[2] == 8'hFF;
    short_form = !long_form && hdr[0] == 8'h00 && hdr[1] == 8'hFF;
    len        = long_form ? hdr[3] : hdr[2];
    lcs        = long_form ? hdr[4] : hdr[3];
    lcs_sum    = len + lcs;
    len_limit  = {3'b000, limit_latched} + 9'd1;
    len_room   = {2'b00, len} + 10'd2;
    plen       = 6'(frame_len - 8'd1);

    stat.ack_last = byte_index == 6'd5;
    stat.ack_bad  = (running_sum != 8'd0) ||
                    (rx_byte != nfcrx_pkg::ack_byte(byte_index[2:0]));
    stat.hdr_last = byte_index == 6'd4;

    if (!(long_form || short_form)) begin
      stat.hdr_code = nfcrx_pkg::STAT_BAD_START;
    end else if (lcs_sum != 8'd0) begin
      stat.hdr_code = nfcrx_pkg::STAT_LCS_BAD;
    end else if (len == 8'd0 || {1'b0, len} > len_limit) begin
      stat.hdr_code = nfcrx_pkg::STAT_LEN_RANGE;
    end else if (len_room > 10'(BODY_BYTES) || (len - 8'd1) > 8'(nfcrx_pkg::MAX_PAYLOAD)) begin
      stat.hdr_code = nfcrx_pkg::STAT_TOO_LONG;
    end else begin
      stat.hdr_code = nfcrx_pkg::STAT_OK;
    end

    stat.body_last = {2'b00, byte_index} == frame_len + 8'd1;

    if (tfi != nfcrx_pkg::RESP_TFI) begin
      stat.fin_code = nfcrx_pkg::STAT_BAD_TFI;
    end else if (running_sum != 8'd0) begin
      stat.fin_code = nfcrx_pkg::STAT_BAD_DCS;
    end else begin
      stat.fin_code = nfcrx_pkg::STAT_OK;
    end

    stat.plen_zero  = plen == 6'd0;
    stat.drain_last = drain_cnt == plen - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      frame_len     <= '0;
      running_sum   <= '0;
      limit_latched <= '0;
      drain_cnt     <= '0;
    end else begin
      if (cmd.start) begin
        limit_latched <= max_payload;
        byte_index    <= '0;
        frame_len     <= '0;
        running_sum   <= '0;
      end else if (cmd.ack_byte) begin
        if (stat.ack_last) begin
          byte_index  <= '0;
          running_sum <= '0;
        end else begin
          byte_index <= byte_index + 6'd1;
          if (stat.ack_bad) begin
            running_sum <= 8'd1;
          end
        end
      end else if (cmd.hdr_byte) begin
        byte_index <= byte_index + 6'd1;
      end else if (cmd.hdr_take) begin
        frame_len <= len;
        if (short_form) begin
          running_sum <= hdr[4];
          byte_index  <= 6'd1;
        end else begin
          running_sum <= '0;
          byte_index  <= '0;
        end
      end else if (cmd.body_byte) begin
        if ({2'b00, byte_index} <= frame_len) begin
          running_sum <= running_sum + rx_byte;
        end
        byte_index <= byte_index + 6'd1;
      end
      if (cmd.drain_init) begin
        drain_cnt <= '0;
      end else if (cmd.rd_load) begin
        drain_cnt <= drain_cnt + 6'd1;
      end
    end
  end

  // header bytes and the TFI hold no reset
  always_ff @(posedge clk) begin
    if (cmd.hdr_byte) begin
      hdr[byte_index[2:0]] <= rx_byte;
    end
    if (cmd.hdr_take && short_form) begin
      tfi <= hdr[4];
    end else if (cmd.body_byte && byte_index == 6'd0) begin
      tfi <= rx_byte;
    end
  end

  // body memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.body_byte) begin
      body_mem[AW'(byte_index)] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rdata <= body_mem[AW'(drain_cnt + 6'd1)];
    end
  end

  always_comb begin
    push     = cmd.err_push || cmd.empty_push || cmd.rd_load;
    push_res = '0;
    push_res.last = 1'b1;
    if (cmd.err_push) begin
      push_res.status = cmd.err_code;
    end else if (cmd.rd_load) begin
      push_res.status       = nfcrx_pkg::STAT_OK;
      push_res.payload_byte = rdata;
      push_res.byte_valid   = 1'b1;
      push_res.data_len     = plen;
      push_res.last         = stat.drain_last;
    end
  end

endmodule

@@ rtl/nfcrx_outq.sv @@
// Two-deep result buffer: a holding slot in front of the output register.
// Depends on nfcrx_pkg for the result type.
module nfcrx_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nfcrx_pkg::res_t  push_res,
  output logic             res_free,
  output logic             out_valid,
  input  logic             out_stall,
  output nfcrx_pkg::res_t  out_res
);

  logic            res_valid;
  nfcrx_pkg::res_t res_hold;
  logic            out_load;

  assign res_free = !res_valid;
  assign out_load = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        res_valid <= 1'b1;
      end else if (out_load) begin
        res_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_hold <= push_res;
    end
    if (out_load) begin
      out_res <= res_hold;
    end
  end

endmodule
